>>> hdl/arrowhead_vertex_generator_assert.svh
`ifndef ARROWHEAD_VERTEX_GENERATOR_ASSERT_SVH
`define ARROWHEAD_VERTEX_GENERATOR_ASSERT_SVH

// Assertion checked at every rising clock edge outside reset.
`define AVG_ASSERT(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication into the next clock edge.
`define AVG_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

>>> hdl/avg_pkg.sv
package avg_pkg;

  localparam int TURN_BITS = 24;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;
  localparam int LEN_W = 12;
  localparam int ANG_W = 15;
  localparam int COORD_W = 16;
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] LAST_VERTEX = 3'd5;

  typedef enum logic [1:0] {
    REG_INNER_LEN = 2'd0,
    REG_OUTER_LEN = 2'd1,
    REG_INNER_ANG = 2'd2,
    REG_OUTER_ANG = 2'd3
  } cfg_reg_t;

  function automatic logic [21:0] atan_turn24(input int unsigned i);
    logic [21:0] r;
    unique case (i)
      0: r = 22'd2097152;
      1: r = 22'd1238021;
      2: r = 22'd654136;
      3: r = 22'd332050;
      4: r = 22'd166669;
      5: r = 22'd83416;
      6: r = 22'd41718;
      7: r = 22'd20860;
      8: r = 22'd10430;
      9: r = 22'd5215;
      10: r = 22'd2608;
      11: r = 22'd1304;
      12: r = 22'd652;
      13: r = 22'd326;
      14: r = 22'd163;
      15: r = 22'd81;
      16: r = 22'd41;
      17: r = 22'd20;
      18: r = 22'd10;
      19: r = 22'd5;
      20: r = 22'd3;
      21: r = 22'd1;
      22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/arrowhead_vertex_generator.sv
// Channel  Direction  Beat
// s_*      in         one segment: start point and tip point
// m_*      out        one polygon vertex, six per segment, tlast on vertex 5
// cfg_*    in         register write, one per cycle
//
// A segment produces six vertex beats, one per cycle while m_tready does not stall;
// the vertex sequencer takes a new segment only when idle or while it issues vertex 5.
// Reset clears all valid bits and the sequencer and loads the four registers
// with their defaults.
// A stall on m_tready holds the whole vertex pipeline in place.
module arrowhead_vertex_generator
  import avg_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // start_x, start_y, tip_x, tip_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // vertex_index, vertex_x, vertex_y, zero fill
  output logic        m_tlast,   // last_vertex
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);

  localparam int N = CORDIC_STEPS;
  localparam int SH = 34 - COORD_FRAC_BITS;
  localparam int PW = 46;
  localparam logic signed [PW-1:0] RND = PW'(1) << (SH - 1);
  localparam logic signed [24:0] QUART = 25'sh0400000;
  localparam logic signed [24:0] HALF = 25'sh0800000;

  logic [LEN_W-1:0] inner_len, outer_len;
  logic [ANG_W-1:0] inner_ang, outer_ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_len <= 12'd320;
      outer_len <= 12'd400;
      inner_ang <= 15'd2367;
      outer_ang <= 15'd4733;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_INNER_LEN: inner_len <= cfg_wdata[LEN_W-1:0];
        REG_OUTER_LEN: outer_len <= cfg_wdata[LEN_W-1:0];
        REG_INNER_ANG: inner_ang <= cfg_wdata;
        REG_OUTER_ANG: outer_ang <= cfg_wdata;
      endcase
    end
  end

  logic en, vadv, seq_take;
  logic busy;
  logic [IDX_W-1:0] cnt;

  assign en = !m_tvalid || m_tready;

  // Vectoring pipeline for the direction angle.
  logic signed [31:0] vx [0:N];
  logic signed [31:0] vy [0:N];
  logic signed [25:0] vz [0:N];
  logic [63:0] vpt [0:N];
  logic vzero [0:N];
  logic vval [0:N];

  assign seq_take = en && vval[N] && (!busy || cnt == LAST_VERTEX);
  assign vadv = en && (!vval[N] || seq_take);
  assign s_tready = vadv;

  logic signed [16:0] dx_in, dy_in;
  assign dx_in = 17'(signed'(s_tdata[47:32])) - 17'(signed'(s_tdata[15:0]));
  assign dy_in = 17'(signed'(s_tdata[63:48])) - 17'(signed'(s_tdata[31:16]));

  always_ff @(posedge clk) begin
    if (rst) begin
      vval[0] <= 1'b0;
    end else if (vadv) begin
      vval[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (vadv) begin
      vpt[0] <= s_tdata;
      vzero[0] <= (dx_in == 17'sd0) && (dy_in == 17'sd0);
      if (dx_in < 0) begin
        vx[0] <= -(32'(dx_in) <<< 12);
        vy[0] <= -(32'(dy_in) <<< 12);
        vz[0] <= 26'sh0800000;
      end else begin
        vx[0] <= 32'(dx_in) <<< 12;
        vy[0] <= 32'(dy_in) <<< 12;
        vz[0] <= 26'sd0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [25:0] AT = 26'(atan_turn24(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        vval[i+1] <= 1'b0;
      end else if (vadv) begin
        vval[i+1] <= vval[i];
      end
    end
    always_ff @(posedge clk) begin
      if (vadv) begin
        vpt[i+1] <= vpt[i];
        vzero[i+1] <= vzero[i];
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + AT;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - AT;
        end
      end
    end
  end

  // Vertex sequencer: holds one segment and issues six jobs.
  logic [63:0] spt;
  logic [TURN_BITS-1:0] sdir;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (en) begin
      if (seq_take) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == LAST_VERTEX) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq_take) begin
      spt <= vpt[N];
      sdir <= vzero[N] ? '0 : vz[N][TURN_BITS-1:0];
    end
  end

  logic [TURN_BITS-1:0] j_ang, j_theta;
  logic [LEN_W-1:0] j_len;
  logic j_sub, j_barb;
  logic [31:0] j_base;
  logic signed [24:0] j_zs, j_z;
  logic j_neg;

  always_comb begin
    j_barb = 1'b1;
    j_sub = 1'b0;
    j_len = inner_len;
    j_ang = TURN_BITS'(inner_ang) << 8;
    j_base = spt[63:32];
    unique case (cnt)
      3'd0: begin
        j_barb = 1'b0;
        j_base = spt[31:0];
      end
      3'd1: begin
      end
      3'd2: begin
        j_len = outer_len;
        j_ang = TURN_BITS'(outer_ang) << 8;
      end
      3'd3: j_barb = 1'b0;
      3'd4: begin
        j_len = outer_len;
        j_ang = TURN_BITS'(outer_ang) << 8;
        j_sub = 1'b1;
      end
      default: j_sub = 1'b1;
    endcase
    j_theta = j_sub ? sdir - j_ang : sdir + j_ang;
    j_zs = 25'(signed'(j_theta));
    j_neg = 1'b0;
    j_z = j_zs;
    if (j_zs > QUART) begin
      j_z = j_zs - HALF;
      j_neg = 1'b1;
    end else if (j_zs < -QUART) begin
      j_z = j_zs + HALF;
      j_neg = 1'b1;
    end
  end

  // Rotation pipeline for cosine and sine.
  logic signed [32:0] rx [0:N];
  logic signed [32:0] ry [0:N];
  logic signed [24:0] rz [0:N];
  logic rneg [0:N];
  logic rbarb [0:N];
  logic rval [0:N];
  logic [LEN_W-1:0] rlen [0:N];
  logic [31:0] rbase [0:N];
  logic [IDX_W-1:0] rk [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      rval[0] <= 1'b0;
    end else if (en) begin
      rval[0] <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= 33'(CORDIC_GAIN_Q30);
      ry[0] <= '0;
      rz[0] <= j_z;
      rneg[0] <= j_neg;
      rbarb[0] <= j_barb;
      rlen[0] <= j_len;
      rbase[0] <= j_base;
      rk[0] <= cnt;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [24:0] AT = 25'(atan_turn24(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        rval[i+1] <= 1'b0;
      end else if (en) begin
        rval[i+1] <= rval[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rneg[i+1] <= rneg[i];
        rbarb[i+1] <= rbarb[i];
        rlen[i+1] <= rlen[i];
        rbase[i+1] <= rbase[i];
        rk[i+1] <= rk[i];
        if (rz[i] >= 0) begin
          rx[i+1] <= rx[i] - (ry[i] >>> i);
          ry[i+1] <= ry[i] + (rx[i] >>> i);
          rz[i+1] <= rz[i] - AT;
        end else begin
          rx[i+1] <= rx[i] + (ry[i] >>> i);
          ry[i+1] <= ry[i] - (rx[i] >>> i);
          rz[i+1] <= rz[i] + AT;
        end
      end
    end
  end

  // Scale by barb length.
  logic pval, pbarb;
  logic signed [PW-1:0] pmx, pmy;
  logic [31:0] pbase;
  logic [IDX_W-1:0] pk;
  logic signed [32:0] cx, cy;
  logic signed [12:0] slen;

  assign cx = rneg[N] ? -rx[N] : rx[N];
  assign cy = rneg[N] ? -ry[N] : ry[N];
  assign slen = signed'({1'b0, rlen[N]});

  always_ff @(posedge clk) begin
    if (rst) begin
      pval <= 1'b0;
    end else if (en) begin
      pval <= rval[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pmx <= PW'(slen) * PW'(cx);
      pmy <= PW'(slen) * PW'(cy);
      pbase <= rbase[N];
      pbarb <= rbarb[N];
      pk <= rk[N];
    end
  end

  // Round, subtract from the tip and saturate.
  logic signed [PW-1:0] offx, offy;
  logic signed [20:0] difx, dify;
  logic signed [15:0] satx, saty;

  assign offx = (pmx + RND) >>> SH;
  assign offy = (pmy + RND) >>> SH;
  assign difx = 21'(signed'(pbase[15:0])) - offx[20:0];
  assign dify = 21'(signed'(pbase[31:16])) - offy[20:0];

  always_comb begin
    if (difx > 21'sd32767) begin
      satx = 16'sh7FFF;
    end else if (difx < -21'sd32768) begin
      satx = 16'sh8000;
    end else begin
      satx = difx[15:0];
    end
    if (dify > 21'sd32767) begin
      saty = 16'sh7FFF;
    end else if (dify < -21'sd32768) begin
      saty = 16'sh8000;
    end else begin
      saty = dify[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= pval;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata[2:0] <= pk;
      m_tdata[18:3] <= pbarb ? satx : pbase[15:0];
      m_tdata[34:19] <= pbarb ? saty : pbase[31:16];
      m_tdata[39:35] <= '0;
      m_tlast <= (pk == LAST_VERTEX);
    end
  end

endmodule

>>> hdl/avg_checker.sv
`include "arrowhead_vertex_generator_assert.svh"

module avg_checker
  import avg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  logic [IDX_W-1:0] expect_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_idx <= '0;
    end else if (m_tvalid && m_tready) begin
      expect_idx <= (m_tdata[2:0] == LAST_VERTEX) ? '0 : m_tdata[2:0] + 3'd1;
    end
  end

  `AVG_ASSERT(a_last_on_five, clk, rst, !m_tvalid || (m_tlast == (m_tdata[2:0] == LAST_VERTEX)), "tlast does not match vertex five")
  `AVG_ASSERT(a_index_order, clk, rst, !m_tvalid || (m_tdata[2:0] == expect_idx), "vertex index out of order")
  `AVG_ASSERT(a_index_range, clk, rst, !m_tvalid || (m_tdata[2:0] <= LAST_VERTEX), "vertex index beyond five")
  `AVG_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled beat changed")

endmodule

bind arrowhead_vertex_generator avg_checker u_avg_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tlast(m_tlast)
);
